/* sv/nscc_pkg.sv */
// Package for the NMEA sentence checksum checker.
// Holds the sentence kind type, the result word type and character decode helpers.
// No dependencies.
package nscc_pkg;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_GGA  = 3'd1,
    KIND_GLL  = 3'd2,
    KIND_GSA  = 3'd3,
    KIND_GSV  = 3'd4,
    KIND_RMC  = 3'd5,
    KIND_ZDA  = 3'd6
  } kind_t;

  typedef struct packed {
    logic       ok;
    kind_t      kind;
    logic       en;
    logic [7:0] sum;
  } result_t;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] PRINT_LO    = 8'h20;
  localparam logic [7:0] PRINT_HI    = 8'h7E;
  localparam logic [2:0] POS_MAX     = 3'd7;
  localparam logic [2:0] POS_TYPE0   = 3'd2;
  localparam logic [2:0] POS_TYPE1   = 3'd3;
  localparam logic [2:0] POS_TYPE2   = 3'd4;
  localparam int         MASK_W      = 6;

  function automatic kind_t kind_of(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] c);
    kind_t k;
    begin
      k = KIND_NONE;
      if (a == 8'h47) begin
        if (b == 8'h47 && c == 8'h41) k = KIND_GGA;
        else if (b == 8'h4C && c == 8'h4C) k = KIND_GLL;
        else if (b == 8'h53 && c == 8'h41) k = KIND_GSA;
        else if (b == 8'h53 && c == 8'h56) k = KIND_GSV;
      end else if (a == 8'h52) begin
        if (b == 8'h4D && c == 8'h43) k = KIND_RMC;
      end else if (a == 8'h5A) begin
        if (b == 8'h44 && c == 8'h41) k = KIND_ZDA;
      end
      return k;
    end
  endfunction

  // Returns {digit valid, digit value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    begin
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      return r;
    end
  endfunction

endpackage

/* sv/nscc_in_reg.sv */
// Input register of the NMEA sentence checksum checker.
// Holds one received character until the tracker takes it; uses nscc_pkg nothing.
module nscc_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_char,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_char
);

  logic       held_valid_next;

  assign in_ready = !held_valid || take;

  always_comb begin
    held_valid_next = held_valid;
    if (in_valid && in_ready) begin
      held_valid_next = 1'b1;
    end else if (take) begin
      held_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_char <= rx_char;
    end
  end

endmodule

/* sv/nscc_tracker.sv */
// Sentence state tracker of the NMEA sentence checksum checker.
// Updates the running sum, type characters and flags per character; uses nscc_pkg.
module nscc_tracker (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [7:0]        ch,
  input  logic              cfg_we,
  input  logic [5:0]        cfg_wdata,
  output logic              emit,
  output nscc_pkg::result_t res
);
  import nscc_pkg::*;

  logic [MASK_W-1:0] mask;
  logic [7:0] running_xor, running_xor_next;
  logic [2:0] char_position, char_position_next;
  logic       sentence_started, sentence_started_next;
  logic       star_seen, star_seen_next;
  logic       hex_digits_active, hex_digits_active_next;
  logic [7:0] received_sum, received_sum_next;
  logic [7:0] type0, type0_next, type1, type1_next, type2, type2_next;

  logic       printable;
  logic [4:0] hex;
  logic [MASK_W:0] en_vec;

  always_comb begin
    printable = (ch >= PRINT_LO) && (ch <= PRINT_HI);
    hex       = hex_digit(ch);
    en_vec    = {mask, 1'b0};

    res.ok   = star_seen && (running_xor == received_sum);
    res.kind = kind_of(type0, type1, type2);
    res.en   = res.ok && en_vec[res.kind];
    res.sum  = running_xor;
    emit     = go && !printable && sentence_started;

    running_xor_next       = running_xor;
    char_position_next     = char_position;
    sentence_started_next  = sentence_started;
    star_seen_next         = star_seen;
    hex_digits_active_next = hex_digits_active;
    received_sum_next      = received_sum;
    type0_next             = type0;
    type1_next             = type1;
    type2_next             = type2;

    if (go) begin
      if (!printable || ch == CHAR_DOLLAR) begin
        if (ch == CHAR_DOLLAR || (sentence_started && res.ok)) begin
          running_xor_next       = '0;
          char_position_next     = '0;
          sentence_started_next  = 1'b0;
          star_seen_next         = 1'b0;
          hex_digits_active_next = 1'b0;
          received_sum_next      = '0;
          type0_next             = '0;
          type1_next             = '0;
          type2_next             = '0;
        end
      end else begin
        sentence_started_next = 1'b1;
        if (char_position == POS_TYPE0) type0_next = ch;
        if (char_position == POS_TYPE1) type1_next = ch;
        if (char_position == POS_TYPE2) type2_next = ch;
        if (char_position != POS_MAX) char_position_next = char_position + 3'd1;
        if (!star_seen) begin
          if (ch == CHAR_STAR) begin
            star_seen_next         = 1'b1;
            hex_digits_active_next = 1'b1;
          end else begin
            running_xor_next = running_xor ^ ch;
          end
        end else if (hex_digits_active) begin
          if (!hex[4]) begin
            hex_digits_active_next = 1'b0;
          end else begin
            received_sum_next = {received_sum[3:0], hex[3:0]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask              <= '1;
      running_xor       <= '0;
      char_position     <= '0;
      sentence_started  <= 1'b0;
      star_seen         <= 1'b0;
      hex_digits_active <= 1'b0;
      received_sum      <= '0;
      type0             <= '0;
      type1             <= '0;
      type2             <= '0;
    end else begin
      if (cfg_we) begin
        mask <= cfg_wdata;
      end
      running_xor       <= running_xor_next;
      char_position     <= char_position_next;
      sentence_started  <= sentence_started_next;
      star_seen         <= star_seen_next;
      hex_digits_active <= hex_digits_active_next;
      received_sum      <= received_sum_next;
      type0             <= type0_next;
      type1             <= type1_next;
      type2             <= type2_next;
    end
  end

endmodule

/* sv/nscc_out_reg.sv */
// Result register of the NMEA sentence checksum checker.
// Holds one result word until the consumer takes it; uses nscc_pkg.
module nscc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  nscc_pkg::result_t res_in,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output nscc_pkg::result_t res_out
);
  import nscc_pkg::*;

  logic out_valid_next;

  assign free = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

/* sv/nmea_sentence_checksum_checker_core.sv */
// Top level of the NMEA sentence checksum checker.
// Instantiates nscc_in_reg, nscc_tracker and nscc_out_reg; uses nscc_pkg.
// The block takes one received character per clock cycle, every cycle, as long as the
// result register is free or being emptied. A result word is registered: the character
// that closes a sentence is held in the input register while the tracker forms the
// result from its state in combinational logic, and the result then loads the result
// register. A full result register that is not being read keeps the character in the
// input register and stalls the input. Characters that produce no result still pass
// through the tracker one per cycle while the input is not stalled.
module nmea_sentence_checksum_checker_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       checksum_ok,
  output logic [2:0] sentence_kind,
  output logic       kind_enabled,
  output logic [7:0] computed_sum,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata
);
  import nscc_pkg::*;

  logic       held_valid;
  logic [7:0] held_char;
  logic       out_free;
  logic       go;
  logic       emit;
  result_t    res_new;
  result_t    res_out;

  assign go = held_valid && out_free;

  nscc_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_char    (rx_char),
    .take       (go),
    .held_valid (held_valid),
    .held_char  (held_char)
  );

  nscc_tracker u_trk (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .ch        (held_char),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .emit      (emit),
    .res       (res_new)
  );

  nscc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .res_in    (res_new),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign checksum_ok   = res_out.ok;
  assign sentence_kind = 3'(res_out.kind);
  assign kind_enabled  = res_out.en;
  assign computed_sum  = res_out.sum;

`ifndef ASSERT_OFF
  a_en_needs_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind_enabled |-> checksum_ok)
    else $error("Kind enabled without a passing checksum.");

  a_en_needs_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind_enabled |-> sentence_kind != 3'(KIND_NONE))
    else $error("Kind enabled with no sentence kind.");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && held_valid |-> !in_ready)
    else $error("Input taken while the pipeline is stalled and full.");
`endif

endmodule
